### sv/ecat_pkg.sv
// ----------------------------------------------------------------------------
// ECAM address translation package
// Shared widths, request field positions, codes and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecat_pkg;

   localparam int DEFAULT_ENTRIES = 8;

   localparam int ADDR_W     = 64;
   localparam int SEGMENT_W  = 16;
   localparam int BUS_W      = 8;
   localparam int DEVICE_W   = 5;
   localparam int FUNC_W     = 3;
   localparam int OFFSET_W   = 12;
   localparam int SLOT_W     = 3;
   localparam int COUNT_W    = 4;
   localparam int CSR_DATA_W = 64;
   localparam int REL_W      = BUS_W + DEVICE_W + FUNC_W + OFFSET_W;

   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = ADDR_W;

   localparam int SLOT_LSB      = 0;
   localparam int SEGMENT_LSB   = SLOT_LSB + SLOT_W;
   localparam int START_BUS_LSB = SEGMENT_LSB + SEGMENT_W;
   localparam int END_BUS_LSB   = START_BUS_LSB + BUS_W;
   localparam int BASE_LSB      = END_BUS_LSB + BUS_W;
   localparam int BUS_LSB       = BASE_LSB + ADDR_W;
   localparam int DEVICE_LSB    = BUS_LSB + BUS_W;
   localparam int FUNC_LSB      = DEVICE_LSB + DEVICE_W;
   localparam int OFFSET_LSB    = FUNC_LSB + FUNC_W;

   typedef enum logic [0:0] {
      OP_LOAD      = 1'b0,
      OP_TRANSLATE = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_ENTRY_COUNT   = 1'b0,
      CSR_WINDOW_OFFSET = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    base;
      logic [BUS_W-1:0]     last_bus;
      logic [BUS_W-1:0]     first_bus;
      logic [SEGMENT_W-1:0] segment;
   } window_type;

   localparam int WINDOW_W = $bits(window_type);

   typedef struct packed {
      logic capture;
      logic write_slot;
      logic scan_first;
      logic scan_next;
      logic take_sum;
      logic finish;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic hit;
      logic last;
   } dp_status_type;

endpackage

`default_nettype wire

### sv/ecat_ram.sv
// ----------------------------------------------------------------------------
// ECAM address translation window RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/ecat_ctrl.sv
// ----------------------------------------------------------------------------
// ECAM address translation controller
// Sequences request capture, the window scan, the final add and the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecat_ctrl
   import ecat_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic          req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      IDLE,
      CHECK,
      ADD,
      RESPOND
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (op_type'(req_tuser) == OP_LOAD) begin
                  cmd.write_slot = 1'b1;
                  state_in       = RESPOND;
               end else if (status.count_zero) begin
                  state_in = RESPOND;
               end else begin
                  cmd.scan_first = 1'b1;
                  state_in       = CHECK;
               end
            end
         end
         CHECK: begin
            if (status.hit) begin
               cmd.take_sum = 1'b1;
               state_in     = ADD;
            end else if (status.last) begin
               state_in = RESPOND;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ADD: begin
            cmd.finish = 1'b1;
            state_in   = RESPOND;
         end
         RESPOND: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### sv/ecat_dp.sv
// ----------------------------------------------------------------------------
// ECAM address translation datapath
// Holds the registers, the window RAM, the scan index, the match and the adds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecat_dp
   import ecat_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire ctrl_cmd_type           cmd,
   output dp_status_type               status,
   output logic                        rsp_tuser,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic [COUNT_W-1:0]   entry_count_ff;
   logic [ADDR_W-1:0]    window_offset_ff;
   logic [SEGMENT_W-1:0] segment_ff;
   logic [BUS_W-1:0]     bus_ff;
   logic [DEVICE_W-1:0]  device_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [OFFSET_W-1:0]  offset_ff;
   logic [CW-1:0]        idx_ff;
   logic [ADDR_W-1:0]    sum_ff;
   logic                 res_found_ff;
   logic [ADDR_W-1:0]    res_addr_ff;
   logic                 rsp_found_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;

   logic [SLOT_W-1:0]    req_slot;
   logic [AW+SLOT_W-1:0] slot_ext;
   logic                 slot_in_range;
   window_type           wr_window;
   window_type           rd_window;
   logic [WINDOW_W-1:0]  rd_data;
   logic [CW-1:0]        count;
   logic [CW-1:0]        next_idx;
   logic [AW-1:0]        rd_addr;
   logic [BUS_W-1:0]     bus_delta;
   logic [REL_W-1:0]     rel;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= '0;
         window_offset_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ENTRY_COUNT:   entry_count_ff   <= csr_data[COUNT_W-1:0];
            CSR_WINDOW_OFFSET: window_offset_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_slot           = req_tdata[SLOT_LSB +: SLOT_W];
   assign slot_ext           = {{AW{1'b0}}, req_slot};
   assign slot_in_range      = 32'(req_slot) < ENTRIES;
   assign wr_window.segment   = req_tdata[SEGMENT_LSB +: SEGMENT_W];
   assign wr_window.first_bus = req_tdata[START_BUS_LSB +: BUS_W];
   assign wr_window.last_bus  = req_tdata[END_BUS_LSB +: BUS_W];
   assign wr_window.base      = req_tdata[BASE_LSB +: ADDR_W];

   always_comb begin
      if (32'(entry_count_ff) > ENTRIES) begin
         count = CW'(ENTRIES);
      end else begin
         count = CW'(entry_count_ff);
      end
   end

   assign next_idx = idx_ff + CW'(1);
   assign rd_addr  = cmd.scan_next ? next_idx[AW-1:0] : '0;

   ecat_ram #(
      .WIDTH (WINDOW_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.write_slot && slot_in_range),
      .wr_addr (slot_ext[AW-1:0]),
      .wr_data (wr_window),
      .rd_en   (cmd.scan_first || cmd.scan_next),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_window = window_type'(rd_data);
   assign bus_delta = bus_ff - rd_window.first_bus;
   assign rel       = {bus_delta, device_ff, func_ff, offset_ff};

   assign status.count_zero = (count == '0);
   assign status.hit        = (rd_window.segment == segment_ff)
                              && (rd_window.first_bus <= bus_ff)
                              && (rd_window.last_bus >= bus_ff);
   assign status.last       = (next_idx == count);

   always_ff @(posedge clock) begin
      if (cmd.scan_first) begin
         idx_ff <= '0;
      end else if (cmd.scan_next) begin
         idx_ff <= next_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         segment_ff   <= req_tdata[SEGMENT_LSB +: SEGMENT_W];
         bus_ff       <= req_tdata[BUS_LSB +: BUS_W];
         device_ff    <= req_tdata[DEVICE_LSB +: DEVICE_W];
         func_ff      <= req_tdata[FUNC_LSB +: FUNC_W];
         offset_ff    <= req_tdata[OFFSET_LSB +: OFFSET_W];
         res_found_ff <= 1'b0;
         res_addr_ff  <= '0;
      end else if (cmd.finish) begin
         res_found_ff <= 1'b1;
         res_addr_ff  <= sum_ff + window_offset_ff;
      end
      if (cmd.take_sum) begin
         sum_ff <= rd_window.base + {{(ADDR_W-REL_W){1'b0}}, rel};
      end
      if (cmd.out_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_addr_ff  <= res_addr_ff;
      end
   end

   assign rsp_tuser = rsp_found_ff;
   assign rsp_tdata = rsp_addr_ff;

endmodule

`default_nettype wire

### sv/ecam_config_address_translate.sv
// ----------------------------------------------------------------------------
// ECAM configuration address translation
// A load request writes its window slot and then responds. A translate that
// hits a window goes on to the final add and a miss ends after the last
// window; the scan reads one window per cycle through the single RAM read
// port. The next request is accepted the cycle after the response is
// registered, so the block never takes a request while one is in progress.
// Reset clears control state and both registers; the window table is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecam_config_address_translate
   import ecat_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // op
   input  wire logic                   req_tuser,
   // slot, segment, start_bus, end_bus, base, bus, device,
   // func_num, reg_offset, one zero pad bit
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // found
   output logic                        rsp_tuser,
   // address
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ecat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ecat_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

### sv/ecat_chk.sv
// ----------------------------------------------------------------------------
// ECAM address translation checker
// Port level properties of the translation block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecat_chk
   import ecat_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic                   rsp_tuser,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("Response changed while stalled.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("Response without a hit carries a nonzero address.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid right after reset.");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second request accepted while one is in progress.");

endmodule

bind ecam_config_address_translate ecat_chk u_chk (.*);

`default_nettype wire
